@@ hw/rtl/pkcomp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcomp_pkg: shared types and constants of the peak compressor
// Register indexes, reset values and the command/status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package pkcomp_pkg;

	// register map
	localparam logic [2:0] REG_ENABLE    = 3'd0;
	localparam logic [2:0] REG_RELEASE   = 3'd1;
	localparam logic [2:0] REG_ATTACK    = 3'd2;
	localparam logic [2:0] REG_KNEE      = 3'd3;
	localparam logic [2:0] REG_THRESHOLD = 3'd4;
	localparam logic [2:0] REG_RATIO     = 3'd5;
	localparam logic [2:0] REG_MAKEUP    = 3'd6;
	localparam int         REG_IDX_BITS  = 3;

	// makeup gain is Q4.20, fixed width
	localparam int MAKEUP_BITS = 24;
	localparam int MAKEUP_FRAC = 20;

	localparam int THR_RESET    = 8388608;
	localparam int RATIO_RESET  = 1677722;
	localparam int MAKEUP_RESET = 1048576;

	// multiplier operand pairs
	typedef logic [3:0] mul_sel_t;
	localparam mul_sel_t M_NONE  = 4'd0;
	localparam mul_sel_t M_REL_X = 4'd1; // (1-kr) * |x|
	localparam mul_sel_t M_REL_Y = 4'd2; // kr * peak
	localparam mul_sel_t M_ATT_X = 4'd3; // (1-ka) * release env
	localparam mul_sel_t M_ATT_Y = 4'd4; // ka * attack env
	localparam mul_sel_t M_RAT   = 4'd5; // ratio * (env - thr)
	localparam mul_sel_t M_KNE_X = 4'd6; // (1-kk) * target
	localparam mul_sel_t M_KNE_Y = 4'd7; // kk * gain
	localparam mul_sel_t M_MAG   = 4'd8; // gain * |x|
	localparam mul_sel_t M_MAK   = 4'd9; // makeup * t

	// accumulator operations
	typedef logic [2:0] acc_op_t;
	localparam acc_op_t ACC_NONE = 3'd0;
	localparam acc_op_t ACC_HALF = 3'd1; // half lsb + product
	localparam acc_op_t ACC_ADD  = 3'd2; // acc + product
	localparam acc_op_t ACC_THR  = 3'd3; // thr << coef bits + product
	localparam acc_op_t ACC_MAKE = 3'd4; // makeup half lsb + product

	// state register writes from the accumulator
	typedef logic [2:0] wr_sel_t;
	localparam wr_sel_t WR_NONE = 3'd0;
	localparam wr_sel_t WR_REL  = 3'd1;
	localparam wr_sel_t WR_ATT  = 3'd2;
	localparam wr_sel_t WR_GAIN = 3'd3;
	localparam wr_sel_t WR_T    = 3'd4;

	typedef struct packed {
		logic     cap;
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		wr_sel_t  wr_sel;
		logic     div_start;
		logic     div_step;
		logic     tgt_one;
		logic     tgt_quo;
		logic     out_load;
	} pkcomp_cmd_t;

	typedef struct packed {
		logic en;
		logic att_low;
	} pkcomp_sts_t;

endpackage

@@ hw/rtl/peak_compressor_top.sv @@
`timescale 1ns / 1ps
// Sequence: an accepted word walks the release, attack, ratio, divider, knee and output states
//   above threshold, skips ratio and divider at or below it, and goes straight to S_FIN when disabled.
// One word is in flight at a time; the bit-serial divider (one quotient bit per cycle) and the
//   single shared multiplier bound how often words are taken.
// Reset: arst_n clears control, envelopes and gain at once and loads register defaults;
//   no clearing pass, words are accepted as soon as reset is released.
// ----------------------------------------------------------------------------
// peak_compressor_top: feedforward peak compressor
// Release peak follower, attack smoother, knee-smoothed gain with a divider,
// then makeup and saturation. A held result does not keep the next word from starting.
// ----------------------------------------------------------------------------
module peak_compressor_top import pkcomp_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 24,
	localparam int KW = COEF_BITS + 1,
	localparam int DW = (KW > SAMPLE_BITS)
		? ((KW > MAKEUP_BITS) ? KW : MAKEUP_BITS)
		: ((SAMPLE_BITS > MAKEUP_BITS) ? SAMPLE_BITS : MAKEUP_BITS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// config write port, no read-back
	input  logic                          wr_en,
	input  logic [REG_IDX_BITS-1:0]       wr_index,
	input  logic [DW-1:0]                 wr_data,
	// sample input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	// compressed output
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	pkcomp_cmd_t cmd;
	pkcomp_sts_t sts;

	// sequencer: one word in flight, the output register decouples the
	// downstream stall so the next word can start while a result waits
	pkcomp_ctrl #(
		.COEF_BITS (COEF_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic: shared multiplier, accumulator, divider and state
	pkcomp_dpath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.sample_in  (sample_in),
		.sample_out (sample_out),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

@@ hw/rtl/pkcomp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcomp_ctrl: sequencer of the peak compressor
// Walks one word through the shared multiplier, accumulator and divider,
// and owns both handshakes.
// ----------------------------------------------------------------------------
module pkcomp_ctrl import pkcomp_pkg::*; #(
	parameter int COEF_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  pkcomp_sts_t sts,
	output pkcomp_cmd_t cmd
);

	localparam int CW = $clog2(COEF_BITS + 1);
	localparam logic [CW-1:0] DIV_LAST = CW'(COEF_BITS);

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_REL_MX   = 5'd1;
	localparam logic [4:0] S_REL_MY   = 5'd2;
	localparam logic [4:0] S_REL_AY   = 5'd3;
	localparam logic [4:0] S_REL_WR   = 5'd4;
	localparam logic [4:0] S_ATT_MX   = 5'd5;
	localparam logic [4:0] S_ATT_MY   = 5'd6;
	localparam logic [4:0] S_ATT_AY   = 5'd7;
	localparam logic [4:0] S_ATT_WR   = 5'd8;
	localparam logic [4:0] S_GCHK     = 5'd9;
	localparam logic [4:0] S_GACC     = 5'd10;
	localparam logic [4:0] S_DIV_INIT = 5'd11;
	localparam logic [4:0] S_DIV      = 5'd12;
	localparam logic [4:0] S_DIV_END  = 5'd13;
	localparam logic [4:0] S_KNE_MX   = 5'd14;
	localparam logic [4:0] S_KNE_MY   = 5'd15;
	localparam logic [4:0] S_KNE_AY   = 5'd16;
	localparam logic [4:0] S_KNE_WR   = 5'd17;
	localparam logic [4:0] S_OUT_M1   = 5'd18;
	localparam logic [4:0] S_OUT_A1   = 5'd19;
	localparam logic [4:0] S_OUT_W1   = 5'd20;
	localparam logic [4:0] S_OUT_M2   = 5'd21;
	localparam logic [4:0] S_OUT_A2   = 5'd22;
	localparam logic [4:0] S_FIN      = 5'd23;

	logic [4:0]    state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = sts.en ? S_REL_MX : S_FIN;
				end
			end
			S_REL_MX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = M_REL_X;
				state_d     = S_REL_MY;
			end
			S_REL_MY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = M_REL_Y;
				cmd.acc_op  = ACC_HALF;
				state_d     = S_REL_AY;
			end
			S_REL_AY: begin
				cmd.acc_op = ACC_ADD;
				state_d    = S_REL_WR;
			end
			S_REL_WR: begin
				cmd.wr_sel = WR_REL;
				state_d    = S_ATT_MX;
			end
			S_ATT_MX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = M_ATT_X;
				state_d     = S_ATT_MY;
			end
			S_ATT_MY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = M_ATT_Y;
				cmd.acc_op  = ACC_HALF;
				state_d     = S_ATT_AY;
			end
			S_ATT_AY: begin
				cmd.acc_op = ACC_ADD;
				state_d    = S_ATT_WR;
			end
			S_ATT_WR: begin
				cmd.wr_sel = WR_ATT;
				state_d    = S_GCHK;
			end
			S_GCHK: begin
				if (sts.att_low) begin
					cmd.tgt_one = 1'b1;
					state_d     = S_KNE_MX;
				end else begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = M_RAT;
					state_d     = S_GACC;
				end
			end
			S_GACC: begin
				cmd.acc_op = ACC_THR;
				state_d    = S_DIV_INIT;
			end
			S_DIV_INIT: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = S_DIV_END;
				end
			end
			S_DIV_END: begin
				cmd.tgt_quo = 1'b1;
				state_d     = S_KNE_MX;
			end
			S_KNE_MX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = M_KNE_X;
				state_d     = S_KNE_MY;
			end
			S_KNE_MY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = M_KNE_Y;
				cmd.acc_op  = ACC_HALF;
				state_d     = S_KNE_AY;
			end
			S_KNE_AY: begin
				cmd.acc_op = ACC_ADD;
				state_d    = S_KNE_WR;
			end
			S_KNE_WR: begin
				cmd.wr_sel = WR_GAIN;
				state_d    = S_OUT_M1;
			end
			S_OUT_M1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = M_MAG;
				state_d     = S_OUT_A1;
			end
			S_OUT_A1: begin
				cmd.acc_op = ACC_HALF;
				state_d    = S_OUT_W1;
			end
			S_OUT_W1: begin
				cmd.wr_sel = WR_T;
				state_d    = S_OUT_M2;
			end
			S_OUT_M2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = M_MAK;
				state_d     = S_OUT_A2;
			end
			S_OUT_A2: begin
				cmd.acc_op = ACC_MAKE;
				state_d    = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/pkcomp_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcomp_dpath: datapath of the peak compressor
// Config registers, envelope and gain state, one shared multiplier with a
// registered product, an accumulator, a bit-serial divider and the output
// register.
// ----------------------------------------------------------------------------
module pkcomp_dpath import pkcomp_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 24,
	localparam int KW = COEF_BITS + 1,
	localparam int DW = (KW > SAMPLE_BITS)
		? ((KW > MAKEUP_BITS) ? KW : MAKEUP_BITS)
		: ((SAMPLE_BITS > MAKEUP_BITS) ? SAMPLE_BITS : MAKEUP_BITS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [REG_IDX_BITS-1:0]       wr_index,
	input  logic [DW-1:0]                 wr_data,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	input  pkcomp_cmd_t                   cmd,
	output pkcomp_sts_t                   sts
);

	localparam int S    = SAMPLE_BITS;
	localparam int C    = COEF_BITS;
	localparam int OPW  = DW;
	localparam int PW   = 2 * OPW;
	localparam int ACCW = PW + 2;
	localparam int YW   = S + 4;

	localparam logic [KW-1:0]   ONE       = {1'b1, {C{1'b0}}};
	localparam logic [KW-1:0]   RATIO_RST = (C > 20) ? KW'(RATIO_RESET) : ONE;
	localparam logic [ACCW-1:0] HALF_ACC  = {{(ACCW-1){1'b0}}, 1'b1} << (C - 1);
	localparam logic [ACCW-1:0] MK_HALF   = {{(ACCW-1){1'b0}}, 1'b1} << (MAKEUP_FRAC - 1);
	localparam logic [YW-1:0]   HALF_RNG  = {{(YW-1){1'b0}}, 1'b1} << (S - 1);

	// configuration
	logic                   en_q;
	logic [KW-1:0]          rel_c_q, att_c_q, knee_c_q, ratio_q;
	logic [S-1:0]           thr_q;
	logic [MAKEUP_BITS-1:0] mk_q;

	// per-word and filter state
	logic signed [S-1:0] raw_q;
	logic [S-1:0]        mag_q;
	logic                neg_q;
	logic                byp_q;
	logic [S-1:0]        rel_q, att_q, t_q;
	logic [KW-1:0]       gain_q, tgt_q;

	logic [OPW-1:0]  opa, opb;
	logic [PW-1:0]   prod_q;
	logic [ACCW-1:0] acc_q;
	logic [S-1:0]    rem_q;
	logic [KW-1:0]   quo_q;
	logic signed [S-1:0] out_q;

	logic [KW-1:0] kr, ka, kk, rg;
	logic [S-1:0]  peak, uin, mag_in;
	logic [S:0]    r2;
	logic          ge;
	logic [YW-1:0] y, lim, ysat;
	logic [S-1:0]  res;

	// coefficients above one act as one
	assign kr = (rel_c_q  > ONE) ? ONE : rel_c_q;
	assign ka = (att_c_q  > ONE) ? ONE : att_c_q;
	assign kk = (knee_c_q > ONE) ? ONE : knee_c_q;
	assign rg = (ratio_q  > ONE) ? ONE : ratio_q;

	assign peak   = (mag_q > rel_q) ? mag_q : rel_q;
	assign uin    = sample_in;
	assign mag_in = sample_in[S-1] ? ((~uin) + {{(S-1){1'b0}}, 1'b1}) : uin;

	assign sts.en      = en_q;
	assign sts.att_low = (att_q == '0) || (att_q <= thr_q);

	always_comb begin
		opa = '0;
		opb = '0;
		unique case (cmd.mul_sel)
			M_REL_X: begin
				opa = OPW'(ONE - kr);
				opb = OPW'(mag_q);
			end
			M_REL_Y: begin
				opa = OPW'(kr);
				opb = OPW'(peak);
			end
			M_ATT_X: begin
				opa = OPW'(ONE - ka);
				opb = OPW'(rel_q);
			end
			M_ATT_Y: begin
				opa = OPW'(ka);
				opb = OPW'(att_q);
			end
			M_RAT: begin
				opa = OPW'(rg);
				opb = OPW'(att_q - thr_q);
			end
			M_KNE_X: begin
				opa = OPW'(ONE - kk);
				opb = OPW'(tgt_q);
			end
			M_KNE_Y: begin
				opa = OPW'(kk);
				opb = OPW'(gain_q);
			end
			M_MAG: begin
				opa = OPW'(gain_q);
				opb = OPW'(mag_q);
			end
			M_MAK: begin
				opa = OPW'(mk_q);
				opb = OPW'(t_q);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// restoring divider step; remainder always stays below the divisor
	assign r2 = {rem_q, quo_q[KW-1]};
	assign ge = (r2 >= {1'b0, att_q});

	// output scaling and saturation on the magnitude
	assign y    = acc_q[MAKEUP_FRAC +: YW];
	assign lim  = neg_q ? HALF_RNG : (HALF_RNG - 1'b1);
	assign ysat = (y > lim) ? lim : y;
	assign res  = neg_q ? ((~ysat[S-1:0]) + {{(S-1){1'b0}}, 1'b1}) : ysat[S-1:0];

	assign sample_out = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= 1'b1;
			rel_c_q  <= '0;
			att_c_q  <= '0;
			knee_c_q <= '0;
			thr_q    <= S'(THR_RESET);
			ratio_q  <= RATIO_RST;
			mk_q     <= MAKEUP_BITS'(MAKEUP_RESET);
			rel_q    <= '0;
			att_q    <= '0;
			gain_q   <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_ENABLE:    en_q     <= wr_data[0];
					REG_RELEASE:   rel_c_q  <= wr_data[KW-1:0];
					REG_ATTACK:    att_c_q  <= wr_data[KW-1:0];
					REG_KNEE:      knee_c_q <= wr_data[KW-1:0];
					REG_THRESHOLD: thr_q    <= wr_data[S-1:0];
					REG_RATIO:     ratio_q  <= wr_data[KW-1:0];
					REG_MAKEUP:    mk_q     <= wr_data[MAKEUP_BITS-1:0];
					default: ;
				endcase
			end
			unique case (cmd.wr_sel)
				WR_REL:  rel_q  <= acc_q[C +: S];
				WR_ATT:  att_q  <= acc_q[C +: S];
				WR_GAIN: gain_q <= acc_q[C +: KW];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			raw_q <= sample_in;
			mag_q <= mag_in;
			neg_q <= sample_in[S-1];
			byp_q <= !en_q;
		end
		if (cmd.mul_en) begin
			prod_q <= opa * opb;
		end
		unique case (cmd.acc_op)
			ACC_HALF: acc_q <= HALF_ACC + ACCW'(prod_q);
			ACC_ADD:  acc_q <= acc_q + ACCW'(prod_q);
			ACC_THR:  acc_q <= (ACCW'(thr_q) << C) + ACCW'(prod_q);
			ACC_MAKE: acc_q <= MK_HALF + ACCW'(prod_q);
			default: ;
		endcase
		if (cmd.wr_sel == WR_T) begin
			t_q <= acc_q[C +: S];
		end
		if (cmd.div_start) begin
			rem_q <= acc_q[KW +: S];
			quo_q <= acc_q[KW-1:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? S'(r2 - {1'b0, att_q}) : r2[S-1:0];
			quo_q <= {quo_q[KW-2:0], ge};
		end
		if (cmd.tgt_one) begin
			tgt_q <= ONE;
		end else if (cmd.tgt_quo) begin
			tgt_q <= quo_q;
		end
		if (cmd.out_load) begin
			out_q <= byp_q ? raw_q : $signed(res);
		end
	end

endmodule

@@ hw/rtl/pkcomp_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcomp_chk: port checker of the peak compressor
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module pkcomp_chk #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [SAMPLE_BITS-1:0] sample_out
);

	// held result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out))
		else $error("pkcomp: output word changed while stalled");

	// one word at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("pkcomp: input accepted while a word is in flight");

	// a new result only comes out of a busy period
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("pkcomp: result without a word in flight");

	// reset empties the output
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("pkcomp: output valid during reset");

endmodule

bind peak_compressor_top pkcomp_chk #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_pkcomp_chk (.*);
